/* design/assert_macros.svh */
// Assertion macros used by the scheduler controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/cts_pkg.sv */
// Package: types, opcodes and sizes of the cyclic transmit scheduler
package cts_pkg;
  localparam int unsigned OneshotDepth  = 16;
  localparam int unsigned PeriodicDepth = 16;
  localparam int unsigned OsIdxW = (OneshotDepth > 1) ? $clog2(OneshotDepth) : 1;
  localparam int unsigned PdIdxW = (PeriodicDepth > 1) ? $clog2(PeriodicDepth) : 1;
  localparam int unsigned OsCntW = $clog2(OneshotDepth + 1);
  localparam int unsigned PdCntW = $clog2(PeriodicDepth + 1);

  typedef enum logic [2:0] {
    OP_ADD_ONESHOT = 3'd0,
    OP_ADD_PERIODIC = 3'd1,
    OP_DEL_PERIODIC = 3'd2,
    OP_CLR_PERIODIC = 3'd3,
    OP_TICK = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [31:0] due_time;
    logic [15:0] repeat_interval;
    logic [31:0] now_ms;
    logic        tx_ready;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [28:0] tx_id;
    logic [3:0]  tx_length;
    logic [63:0] tx_payload;
    logic        tx_from_periodic;
    logic        status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the input item
    logic os_append;   // write item at one-shot tail
    logic pd_append;   // write item at periodic tail
    logic pd_clear;
    logic scan_rst;    // scan index to 0
    logic scan_inc;
    logic os_shift;    // one-shot: entry[idx] <= entry[idx+1]
    logic pd_shift;
    logic os_dec;
    logic pd_dec;
    logic os_pick;     // capture one-shot entry idx as sent frame
    logic pd_pick;     // capture periodic entry idx, start due advance
    logic adv_step;    // one due-advance iteration
    logic pd_reappend; // write advanced entry at tail
    logic set_full;
    logic out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       tx_ready;
    logic       os_full;
    logic       pd_full;
    logic       os_end;     // idx >= oneshot count
    logic       pd_end;
    logic       os_last;    // idx+1 >= oneshot count
    logic       pd_last;
    logic       os_due;     // one-shot entry idx is due
    logic       pd_due;
    logic       pd_match;   // periodic entry idx has the item's id
    logic       adv_done;
  } sts_t;
endpackage

/* design/cts_if.sv */
// Valid/ready channel interfaces for the scheduler
interface cts_in_if;
  import cts_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cts_out_if;
  import cts_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/cts_datapath.sv */
// Datapath: both frame tables, scan index, due-time advance, result register
module cts_datapath
  import cts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  ctl_t      ctl_i,
  output sts_t      sts_o,
  output out_item_t res_o
);
  in_item_t item_q;
  logic [32:0] os_idlen_q [OneshotDepth];
  logic [31:0] os_due_q   [OneshotDepth];
  logic [63:0] os_data_q  [OneshotDepth];
  logic [32:0] pd_idlen_q [PeriodicDepth];
  logic [31:0] pd_due_q   [PeriodicDepth];
  logic [15:0] pd_per_q   [PeriodicDepth];
  logic [63:0] pd_data_q  [PeriodicDepth];
  logic [OsCntW-1:0] os_cnt_q;
  logic [PdCntW-1:0] pd_cnt_q;
  logic [8:0] idx_q;
  logic [32:0] sel_idlen_q;
  logic [63:0] sel_data_q;
  logic [15:0] sel_per_q;
  logic [32:0] adv_due_q; // bit 32 = carry, exact sum kept until above now
  out_item_t res_q;
  logic full_q, from_pd_q, sent_q;

  logic [OsIdxW-1:0] os_i, os_i1, os_t;
  logic [PdIdxW-1:0] pd_i, pd_i1, pd_t;
  logic [15:0] per_in;

  assign os_i  = idx_q[OsIdxW-1:0];
  assign pd_i  = idx_q[PdIdxW-1:0];
  assign os_i1 = (idx_q + 9'd1 < 9'(OneshotDepth)) ? os_i + 1'b1 : os_i;
  assign pd_i1 = (idx_q + 9'd1 < 9'(PeriodicDepth)) ? pd_i + 1'b1 : pd_i;
  assign os_t  = (os_cnt_q < OsCntW'(OneshotDepth)) ? os_cnt_q[OsIdxW-1:0] : '0;
  assign pd_t  = (pd_cnt_q < PdCntW'(PeriodicDepth)) ? pd_cnt_q[PdIdxW-1:0] : '0;
  assign per_in = (item_q.repeat_interval == 16'd0) ? 16'd1 : item_q.repeat_interval;

  always_comb begin
    sts_o.opcode   = item_q.opcode;
    sts_o.tx_ready = item_q.tx_ready;
    sts_o.os_full  = os_cnt_q >= OsCntW'(OneshotDepth);
    sts_o.pd_full  = pd_cnt_q >= PdCntW'(PeriodicDepth);
    sts_o.os_end   = {{(9 > OsCntW ? 9 - OsCntW : 0){1'b0}}, os_cnt_q} <= idx_q;
    sts_o.pd_end   = {{(9 > PdCntW ? 9 - PdCntW : 0){1'b0}}, pd_cnt_q} <= idx_q;
    sts_o.os_last  = {{(9 > OsCntW ? 9 - OsCntW : 0){1'b0}}, os_cnt_q} <= idx_q + 9'd1;
    sts_o.pd_last  = {{(9 > PdCntW ? 9 - PdCntW : 0){1'b0}}, pd_cnt_q} <= idx_q + 9'd1;
    sts_o.os_due   = os_due_q[os_i] < item_q.now_ms;
    sts_o.pd_due   = pd_due_q[pd_i] < item_q.now_ms;
    sts_o.pd_match = pd_idlen_q[pd_i][28:0] == item_q.frame_id;
    sts_o.adv_done = adv_due_q > {1'b0, item_q.now_ms};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_cnt_q <= '0;
      pd_cnt_q <= '0;
      idx_q <= '0;
      full_q <= 1'b0;
      sent_q <= 1'b0;
      from_pd_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        full_q <= 1'b0;
        sent_q <= 1'b0;
        from_pd_q <= 1'b0;
      end
      if (ctl_i.set_full) full_q <= 1'b1;
      if (ctl_i.scan_rst) idx_q <= '0;
      else if (ctl_i.scan_inc) idx_q <= idx_q + 9'd1;
      if (ctl_i.os_append) os_cnt_q <= os_cnt_q + 1'b1;
      else if (ctl_i.os_dec) os_cnt_q <= os_cnt_q - 1'b1;
      if (ctl_i.pd_clear) pd_cnt_q <= '0;
      else if (ctl_i.pd_append || ctl_i.pd_reappend) pd_cnt_q <= pd_cnt_q + 1'b1;
      else if (ctl_i.pd_dec) pd_cnt_q <= pd_cnt_q - 1'b1;
      if (ctl_i.os_pick) begin
        sent_q <= 1'b1;
        from_pd_q <= 1'b0;
      end
      if (ctl_i.pd_pick) begin
        sent_q <= 1'b1;
        from_pd_q <= 1'b1;
      end
    end
  end

  // tables and payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) item_q <= item_i;
    if (ctl_i.os_append) begin
      os_idlen_q[os_t] <= {item_q.frame_length, item_q.frame_id};
      os_due_q[os_t]   <= item_q.due_time;
      os_data_q[os_t]  <= item_q.frame_payload;
    end
    if (ctl_i.os_shift) begin
      os_idlen_q[os_i] <= os_idlen_q[os_i1];
      os_due_q[os_i]   <= os_due_q[os_i1];
      os_data_q[os_i]  <= os_data_q[os_i1];
    end
    if (ctl_i.pd_append) begin
      pd_idlen_q[pd_t] <= {item_q.frame_length, item_q.frame_id};
      pd_due_q[pd_t]   <= item_q.due_time;
      pd_per_q[pd_t]   <= per_in;
      pd_data_q[pd_t]  <= item_q.frame_payload;
    end
    if (ctl_i.pd_shift) begin
      pd_idlen_q[pd_i] <= pd_idlen_q[pd_i1];
      pd_due_q[pd_i]   <= pd_due_q[pd_i1];
      pd_per_q[pd_i]   <= pd_per_q[pd_i1];
      pd_data_q[pd_i]  <= pd_data_q[pd_i1];
    end
    if (ctl_i.pd_reappend) begin
      pd_idlen_q[pd_t] <= sel_idlen_q;
      pd_due_q[pd_t]   <= adv_due_q[31:0];
      pd_per_q[pd_t]   <= sel_per_q;
      pd_data_q[pd_t]  <= sel_data_q;
    end
    if (ctl_i.os_pick) begin
      sel_idlen_q <= os_idlen_q[os_i];
      sel_data_q  <= os_data_q[os_i];
    end
    if (ctl_i.pd_pick) begin
      sel_idlen_q <= pd_idlen_q[pd_i];
      sel_data_q  <= pd_data_q[pd_i];
      sel_per_q   <= (pd_per_q[pd_i] == 16'd0) ? 16'd1 : pd_per_q[pd_i];
      adv_due_q   <= {1'b0, pd_due_q[pd_i]};
    end else if (ctl_i.adv_step) begin
      // repeated add: coarse multiples first, then single periods
      if ({1'b0, item_q.now_ms} - adv_due_q > {1'b0, sel_per_q, 16'd0} &&
          adv_due_q < {1'b0, item_q.now_ms})
        adv_due_q <= adv_due_q + {1'b0, sel_per_q, 16'd0};
      else if ({1'b0, item_q.now_ms} - adv_due_q > {9'd0, sel_per_q, 8'd0} &&
               adv_due_q < {1'b0, item_q.now_ms})
        adv_due_q <= adv_due_q + {9'd0, sel_per_q, 8'd0};
      else
        adv_due_q <= adv_due_q + {17'd0, sel_per_q};
    end
    if (ctl_i.out_load) begin
      res_q.tx_valid         <= sent_q;
      res_q.tx_id            <= sent_q ? sel_idlen_q[28:0] : 29'd0;
      res_q.tx_length        <= sent_q ? sel_idlen_q[32:29] : 4'd0;
      res_q.tx_payload       <= sent_q ? sel_data_q : 64'd0;
      res_q.tx_from_periodic <= sent_q & from_pd_q;
      res_q.status           <= full_q;
    end
  end

  assign res_o = res_q;
endmodule

/* design/cts_ctrl.sv */
// Controller: sequences one item through the table operations
`include "assert_macros.svh"
module cts_ctrl
  import cts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FIND, S_REMOVE, S_APPEND_PD, S_OS_SCAN, S_OS_REM,
    S_PD_SCAN, S_PD_REM, S_ADV, S_REAPPEND, S_RESULT, S_OUT
  } state_e;
  state_e state_q, state_d;
  logic   del_only_q, del_only_d;

  always_comb begin
    state_d = state_q;
    del_only_d = del_only_q;
    ctl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          ctl_o.scan_rst = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESULT;
        unique case (sts_i.opcode)
          OP_ADD_ONESHOT: begin
            if (sts_i.os_full) ctl_o.set_full = 1'b1;
            else ctl_o.os_append = 1'b1;
          end
          OP_ADD_PERIODIC: begin
            del_only_d = 1'b0;
            state_d = S_FIND;
          end
          OP_DEL_PERIODIC: begin
            del_only_d = 1'b1;
            state_d = S_FIND;
          end
          OP_CLR_PERIODIC: ctl_o.pd_clear = 1'b1;
          OP_TICK: if (sts_i.tx_ready) state_d = S_OS_SCAN;
          default: ;
        endcase
      end
      S_FIND: begin
        if (sts_i.pd_end) state_d = del_only_q ? S_RESULT : S_APPEND_PD;
        else if (sts_i.pd_match) state_d = S_REMOVE;
        else ctl_o.scan_inc = 1'b1;
      end
      S_REMOVE: begin
        if (sts_i.pd_last) begin
          ctl_o.pd_dec = 1'b1;
          state_d = del_only_q ? S_RESULT : S_APPEND_PD;
        end else begin
          ctl_o.pd_shift = 1'b1;
          ctl_o.scan_inc = 1'b1;
        end
      end
      S_APPEND_PD: begin
        if (sts_i.pd_full) ctl_o.set_full = 1'b1;
        else ctl_o.pd_append = 1'b1;
        state_d = S_RESULT;
      end
      S_OS_SCAN: begin
        if (sts_i.os_end) begin
          ctl_o.scan_rst = 1'b1;
          state_d = S_PD_SCAN;
        end else if (sts_i.os_due) begin
          ctl_o.os_pick = 1'b1;
          state_d = S_OS_REM;
        end else ctl_o.scan_inc = 1'b1;
      end
      S_OS_REM: begin
        if (sts_i.os_last) begin
          ctl_o.os_dec = 1'b1;
          state_d = S_RESULT;
        end else begin
          ctl_o.os_shift = 1'b1;
          ctl_o.scan_inc = 1'b1;
        end
      end
      S_PD_SCAN: begin
        if (sts_i.pd_end) state_d = S_RESULT;
        else if (sts_i.pd_due) begin
          ctl_o.pd_pick = 1'b1;
          state_d = S_PD_REM;
        end else ctl_o.scan_inc = 1'b1;
      end
      S_PD_REM: begin
        // advance runs beside the removal, but stops once past now
        ctl_o.adv_step = !sts_i.adv_done;
        if (sts_i.pd_last) begin
          ctl_o.pd_dec = 1'b1;
          state_d = S_ADV;
        end else begin
          ctl_o.pd_shift = 1'b1;
          ctl_o.scan_inc = 1'b1;
        end
      end
      S_ADV: begin
        if (sts_i.adv_done) state_d = S_REAPPEND;
        else ctl_o.adv_step = 1'b1;
      end
      S_REAPPEND: begin
        ctl_o.pd_reappend = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        ctl_o.out_load = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      del_only_q <= 1'b0;
    end else begin
      state_q <= state_d;
      del_only_q <= del_only_d;
    end
  end

  `ASSERT_IMPL(a_no_dual_append, clk_i, rst_ni, !(ctl_o.os_append && ctl_o.pd_append))
  `ASSERT_IMPL(a_pick_excl, clk_i, rst_ni, !(ctl_o.os_pick && ctl_o.pd_pick))
  `ASSERT_NEXT(a_out_after_load, clk_i, rst_ni, ctl_o.out_load, out_valid_o)
  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, !(in_ready_o && out_valid_o))
endmodule

/* design/can_cyclic_tx_scheduler.sv */
// Top level of the CAN cyclic transmit scheduler
// Usage: commands and ticks arrive as items on in_if (valid/ready); each
// accepted item gives exactly one result item on out_if. Opcodes add a
// one-shot frame, add or replace a periodic frame, delete a periodic frame,
// clear the periodic table, or tick. A tick with tx_ready sends the first due
// one-shot frame, else the first due periodic frame, which is rescheduled
// past now_ms and moved to the table end.
// Timing: one item at a time. The item is latched on accept; the controller
// then decodes it, walks the tables where the opcode needs it, registers the
// result and shows it on out_if. The due-time advance adds 65536x, then 256x,
// then 1x the interval per cycle and overlaps the removal; the longest advance
// comes with a gap of nearly 2^32 ms and an interval of 1.
// Reset clears both table fill counts; entries are never read above them.
// A stalled result holds on out_if until taken; no new item is accepted
// until then, and the next one can be taken in the cycle after that.
module can_cyclic_tx_scheduler
  import cts_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  cts_in_if.sink    in_if,
  cts_out_if.source out_if
);
  ctl_t ctl;
  sts_t sts;

  cts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  cts_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i(in_if.data),
    .ctl_i (ctl),
    .sts_o (sts),
    .res_o (out_if.data)
  );
endmodule

/* sim/can_cyclic_tx_scheduler_tb.sv */
// Testbench for the CAN cyclic transmit scheduler: directed table, then random traffic
`timescale 1ns / 100ps

module can_cyclic_tx_scheduler_tb;
  import cts_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cts_in_if  cmd_if ();
  cts_out_if tx_if ();

  can_cyclic_tx_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_if.sink),
    .out_if (tx_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scheduler shadow state
  typedef struct {
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] due;
    logic [15:0] per;
  } entry_t;

  entry_t    os_q[$];
  entry_t    pd_q[$];
  out_item_t tx_expect_q[$];
  int        mismatch_cnt;
  int        orphan_cnt;

  function automatic out_item_t sched_step(in_item_t it);
    out_item_t r;
    entry_t    e;
    logic [63:0] steps;
    logic [63:0] nxt;
    int        pos;
    r = '0;
    e.id = it.frame_id;
    e.len = it.frame_length;
    e.data = it.frame_payload;
    e.due = it.due_time;
    e.per = (it.repeat_interval == 16'd0) ? 16'd1 : it.repeat_interval;
    case (it.opcode)
      OP_ADD_ONESHOT: begin
        if (os_q.size() >= OneshotDepth) r.status = 1'b1;
        else os_q.insert(os_q.size(), e);
      end
      OP_ADD_PERIODIC, OP_DEL_PERIODIC: begin
        pos = -1;
        foreach (pd_q[i]) if (pos < 0 && pd_q[i].id == it.frame_id) pos = i;
        if (pos >= 0) pd_q.delete(pos);
        if (it.opcode == OP_ADD_PERIODIC) begin
          if (pd_q.size() >= PeriodicDepth) r.status = 1'b1;
          else pd_q.insert(pd_q.size(), e);
        end
      end
      OP_CLR_PERIODIC: pd_q.delete();
      OP_TICK: begin
        if (it.tx_ready) begin
          pos = -1;
          foreach (os_q[i]) if (pos < 0 && os_q[i].due < it.now_ms) pos = i;
          if (pos >= 0) begin
            e = os_q[pos];
            os_q.delete(pos);
            r.tx_valid = 1'b1; r.tx_id = e.id; r.tx_length = e.len;
            r.tx_payload = e.data;
          end else begin
            foreach (pd_q[i]) if (pos < 0 && pd_q[i].due < it.now_ms) pos = i;
            if (pos >= 0) begin
              e = pd_q[pos];
              pd_q.delete(pos);
              steps = 64'(it.now_ms - e.due) / e.per + 64'd1;
              nxt = 64'(e.due) + steps * 64'(e.per);
              e.due = nxt[31:0];
              pd_q.insert(pd_q.size(), e);
              r.tx_valid = 1'b1; r.tx_id = e.id; r.tx_length = e.len;
              r.tx_payload = e.data; r.tx_from_periodic = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] op, logic [28:0] id, logic [3:0] len,
                                        logic [63:0] pl, logic [31:0] due,
                                        logic [15:0] per, logic [31:0] now, logic rdy);
    in_item_t it;
    it.opcode = op; it.frame_id = id; it.frame_length = len; it.frame_payload = pl;
    it.due_time = due; it.repeat_interval = per; it.now_ms = now; it.tx_ready = rdy;
    return it;
  endfunction

  // valid stays up after the item is taken; idle_gap or the caller drops it
  task automatic send_cmd(in_item_t it);
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    tx_expect_q.insert(tx_expect_q.size(), sched_step(it));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (tx_if.valid && tx_if.ready) begin
      if (tx_expect_q.size() == 0) begin
        orphan_cnt++;
        if (orphan_cnt <= 10) $display("unexpected result %p", tx_if.data);
      end else begin
        if (tx_if.data !== tx_expect_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %p, actual %p", tx_expect_q[0], tx_if.data);
        end
        void'(tx_expect_q.pop_front());
      end
    end
  end

  // random sink stall
  always @(posedge clk_i) begin
    if (!rst_ni) tx_if.ready <= 1'b0;
    else if ($urandom_range(0, 15) == 0) tx_if.ready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) tx_if.ready <= 1'b1;
    else if ($urandom_range(0, 40) == 0) tx_if.ready <= 1'b0;
  end

  initial begin
    #1000000000;
    $display("FAILED: results differ");
    $finish;
  end

  // directed rows: command plus the plainly known result, check_row set where typed
  typedef struct {
    in_item_t  cmd;
    logic      check_row;
    out_item_t res;
  } row_t;

  initial begin
    row_t      rows[$];
    row_t      rw;
    in_item_t  it;
    out_item_t known;
    logic [31:0] now_base;
    logic [28:0] id_pool[8];
    int        n_items;
    int        k;

    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    tx_if.ready  = 1'b0;
    mismatch_cnt = 0;
    orphan_cnt   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on empty tables, unknown opcodes: all zero
    known = '0;
    rw.check_row = 1'b1; rw.res = known;
    rw.cmd = make_cmd(OP_TICK, '1, '1, '1, '1, '1, '1, 1'b1);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(3'd5, '1, '1, '1, '1, '1, '1, 1'b1);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(3'd7, 0, 0, 0, 0, 0, 0, 1'b0);
    rows.insert(rows.size(), rw);
    rw.check_row = 1'b0;
    // extremes of fields, length above 8, zero interval, wrapping due advance
    rw.cmd = make_cmd(OP_ADD_ONESHOT, '1, 4'hf, '1, 32'd0, 16'd0, 0, 0);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_ADD_PERIODIC, 29'd0, 4'd8, 64'h0123456789abcdef,
                      32'hffff_fff0, 16'd0, 0, 0);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_ADD_PERIODIC, 29'd5, 4'd0, 0, 32'hfffffff0, 16'hffff, 0, 0);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, 32'd1, 1'b0);  // not ready
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, 32'd1, 1'b1);  // one-shot
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, '1, 1'b1);     // periodic
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, '1, 1'b1);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, 32'hfffffff0, 1'b1);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_ADD_PERIODIC, 29'd5, 4'd3, 64'h55, 32'd10, 16'd7, 0, 0);
    rows.insert(rows.size(), rw);  // replace
    rw.cmd = make_cmd(OP_DEL_PERIODIC, 29'd77, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_DEL_PERIODIC, 29'd0, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, 32'd10, 1'b1);  // not due
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_TICK, 0, 0, 0, 0, 0, 32'd11, 1'b1);
    rows.insert(rows.size(), rw);
    rw.cmd = make_cmd(OP_CLR_PERIODIC, 0, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), rw);

    foreach (rows[i]) begin
      if (rows[i].check_row) begin
        void'(sched_step(rows[i].cmd));
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= rows[i].cmd;
        @(posedge clk_i);
        while (!cmd_if.ready) @(posedge clk_i);
        tx_expect_q.insert(tx_expect_q.size(), rows[i].res);
      end else begin
        send_cmd(rows[i].cmd);
      end
      idle_gap();
    end

    // fill both tables past full: status set on overflow
    for (k = 0; k < 18; k++) begin
      send_cmd(make_cmd(OP_ADD_ONESHOT, 29'(k), 4'(k), 64'(k), '1, 0, 0, 0));
      send_cmd(make_cmd(OP_ADD_PERIODIC, 29'(100 + k), 4'd2, 64'(k), 32'd0, 16'd3, 0, 0));
    end
    // replace in a full table is not full
    send_cmd(make_cmd(OP_ADD_PERIODIC, 29'd103, 4'd1, 64'd9, 32'd0, 16'd1, 0, 0));
    for (k = 0; k < 20; k++) send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 32'd50, 1'b1));
    send_cmd(make_cmd(OP_CLR_PERIODIC, 0, 0, 0, 0, 0, 0, 0));
    for (k = 0; k < 17; k++) send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0, '1, 1'b1));

    // random part: mostly plausible schedules around a moving now
    now_base = 32'd1000;
    foreach (id_pool[i]) id_pool[i] = 29'($urandom);
    n_items = 0;
    while (n_items < 1800) begin
      it = '0;
      it.frame_id = ($urandom_range(0, 3) == 0) ? 29'($urandom)
                    : id_pool[$urandom_range(0, 7)];
      it.frame_length = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
      it.frame_payload = {$urandom, $urandom};
      it.due_time = ($urandom_range(0, 9) == 0) ? $urandom
                    : now_base + $urandom_range(0, 40) - 20;
      it.repeat_interval = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                           : 16'($urandom_range(0, 30));
      it.tx_ready = ($urandom_range(0, 7) != 0);
      k = $urandom_range(0, 99);
      if (k < 20) it.opcode = OP_ADD_ONESHOT;
      else if (k < 40) it.opcode = OP_ADD_PERIODIC;
      else if (k < 47) it.opcode = OP_DEL_PERIODIC;
      else if (k < 49) it.opcode = OP_CLR_PERIODIC;
      else if (k < 97) it.opcode = OP_TICK;
      else it.opcode = 3'($urandom_range(5, 7));
      now_base = now_base + $urandom_range(0, 6);
      it.now_ms = ($urandom_range(0, 19) == 0) ? $urandom : now_base;
      send_cmd(it);
      if (it.opcode <= OP_TICK) n_items++;
      if (n_items == 900) begin
        // hold off until every result has come
        cmd_if.valid <= 1'b0;
        while (tx_expect_q.size() != 0) @(posedge clk_i);
      end
      idle_gap();
    end

    cmd_if.valid <= 1'b0;
    k = 0;
    while (tx_expect_q.size() != 0 && k < 100000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && orphan_cnt == 0 && tx_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
